// File: design/iso_datetime_to_epoch_seconds_core_macros.svh
// Assertion helpers for the date-time to epoch core.
// Both sample on aclk and are disabled while aresetn is low.
`ifndef ISO_DATETIME_TO_EPOCH_SECONDS_CORE_MACROS_SVH
`define ISO_DATETIME_TO_EPOCH_SECONDS_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ISOEP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ISOEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ISOEP_ASSERT_IMP(label, ante, cons, msg)
`define ISOEP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: design/isoepoch_pkg.sv
`timescale 1ns / 1ps

package isoepoch_pkg;

    // Field being received
    typedef enum logic [2:0] {
        FLD_YEAR   = 3'd0,
        FLD_MONTH  = 3'd1,
        FLD_DAY    = 3'd2,
        FLD_HOUR   = 3'd3,
        FLD_MINUTE = 3'd4,
        FLD_SECOND = 3'd5
    } field_t;

    // Fields of one finished string, as handed to the arithmetic stages
    typedef struct packed {
        logic [7:0] year_off;
        logic [3:0] month_idx;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       bad;
    } date_fields_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [2:0] YEAR_DIGITS  = 3'd4;
    localparam logic [2:0] FIELD_DIGITS = 3'd2;

    localparam logic [13:0] YEAR_MIN   = 14'd1900;
    localparam logic [13:0] YEAR_MAX   = 14'd2100;
    localparam logic [13:0] MONTH_MAX  = 14'd12;
    localparam logic [13:0] DAY_MAX    = 14'd31;
    localparam logic [13:0] HOUR_MAX   = 14'd23;
    localparam logic [13:0] MINSEC_MAX = 14'd59;

    localparam logic [7:0] YEAR_CENTURY_1 = 8'd100;  // 2000
    localparam logic [7:0] YEAR_CENTURY_2 = 8'd200;  // 2100

    localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [19:0] DAYS_PER_YEAR = 20'd365;
    localparam logic [8:0]  EPOCH_YEAR_OFF = 9'd70;   // 1970 - 1900
    localparam logic [8:0]  LEAP_BASE_OFF  = 9'd69;

    // Expected separator after each field
    function automatic logic [7:0] sep_char(input field_t f);
        logic [7:0] c;
        unique case (f)
            FLD_YEAR, FLD_MONTH:  c = CHAR_DASH;
            FLD_DAY:              c = CHAR_T;
            FLD_HOUR, FLD_MINUTE: c = CHAR_COLON;
            default:              c = CHAR_NUL;
        endcase
        return c;
    endfunction

    // Days before the first of each month in a common year; index wraps mod 12
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0, 4'd12: d = 9'd0;
            4'd1, 4'd13: d = 9'd31;
            4'd2, 4'd14: d = 9'd59;
            4'd3, 4'd15: d = 9'd90;
            4'd4:        d = 9'd120;
            4'd5:        d = 9'd151;
            4'd6:        d = 9'd181;
            4'd7:        d = 9'd212;
            4'd8:        d = 9'd243;
            4'd9:        d = 9'd273;
            4'd10:       d = 9'd304;
            4'd11:       d = 9'd334;
            default:     d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: design/iso_datetime_to_epoch_seconds_core.sv
`timescale 1ns / 1ps
// ISO date-time string to Unix seconds.
// Input channel (s_valid/s_ready): one ASCII character of a string
// yyyy-mm-ddThh:mm[:ss] per item; s_is_last marks the final character.
// Result channel (m_valid/m_ready): one item per string, produced by the
// last character: seconds since 1970-01-01 modulo 2^32 and a bad_format flag
// (epoch is 0 when the flag is set). Other characters give no result.
// Throughput: one character per cycle while s_ready is high. Parsing happens in the accept cycle,
// so characters never wait on each other.
// Path: a last character is registered in the field stage, then in the calendar
// stage, then in the days * 86400 multiply stage that drives m_*.
// Backpressure: three elastic stages (fields, days/hms, output register).
// s_ready drops only when the field stage is full and cannot drain, i.e.
// after the receiver has stalled long enough to fill all three stages.
// Reset (aresetn low, synchronous): parse state cleared, all stages emptied.
`include "iso_datetime_to_epoch_seconds_core_macros.svh"

module iso_datetime_to_epoch_seconds_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_epoch_seconds,
    output logic        m_bad_format
);

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    isoepoch_pkg::field_t field_number_reg, field_number_next;
    logic [13:0] field_accumulator_reg, field_accumulator_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic [7:0]  year_offset_reg, year_offset_next;
    logic [3:0]  month_index_reg, month_index_next;
    logic [4:0]  day_of_month_reg, day_of_month_next;
    logic [4:0]  hour_value_reg, hour_value_next;
    logic [5:0]  minute_value_reg, minute_value_next;
    logic        error_seen_reg, error_seen_next;

    // Pipeline control
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic out_free, s2_free, s1_free, s2_adv, s1_adv, in_acc;

    assign out_free = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_ready  = s1_free;
    assign in_acc   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Character decode and field close (accept cycle)
    // ------------------------------------------------------------------
    logic        is_digit, digit_room, sep_hit, stray, overflow;
    logic [3:0]  digit_val;
    logic [2:0]  digit_limit;
    logic [13:0] acc_d;
    logic [2:0]  cnt_d;
    logic        close_en, close_err, end_err;
    logic [7:0]  year_upd;
    logic [3:0]  month_upd;
    logic [4:0]  day_upd, hour_upd;
    logic [5:0]  minute_upd, second_upd;
    logic        err_upd;

    always_comb begin
        is_digit    = (s_char_code >= isoepoch_pkg::CHAR_ZERO) &&
                      (s_char_code <= isoepoch_pkg::CHAR_NINE);
        digit_val   = 4'(s_char_code - isoepoch_pkg::CHAR_ZERO);
        digit_limit = (field_number_reg == isoepoch_pkg::FLD_YEAR) ?
                      isoepoch_pkg::YEAR_DIGITS : isoepoch_pkg::FIELD_DIGITS;
        digit_room  = digit_count_reg < digit_limit;
        sep_hit     = !is_digit && (field_number_reg < isoepoch_pkg::FLD_SECOND) &&
                      (s_char_code == isoepoch_pkg::sep_char(field_number_reg));
        stray       = !is_digit && !sep_hit;
        overflow    = is_digit && !digit_room;

        if (is_digit && digit_room) begin
            acc_d = 14'({field_accumulator_reg, 3'b000}) +
                    14'({field_accumulator_reg, 1'b0}) + 14'(digit_val);
            cnt_d = digit_count_reg + 3'd1;
        end else begin
            acc_d = field_accumulator_reg;
            cnt_d = digit_count_reg;
        end

        // A field closes on its separator, or on the last character while in
        // the minute or second field. A last separator always ends in error:
        // it leaves an empty field open, or ends the string too early.
        close_en = sep_hit || (s_is_last &&
                   ((field_number_reg == isoepoch_pkg::FLD_MINUTE) ||
                    (field_number_reg == isoepoch_pkg::FLD_SECOND)));
        end_err  = s_is_last && (sep_hit ||
                   !((field_number_reg == isoepoch_pkg::FLD_MINUTE) ||
                     (field_number_reg == isoepoch_pkg::FLD_SECOND)));

        year_upd   = year_offset_reg;
        month_upd  = month_index_reg;
        day_upd    = day_of_month_reg;
        hour_upd   = hour_value_reg;
        minute_upd = minute_value_reg;
        second_upd = 6'd0;
        close_err  = 1'b0;

        if (close_en) begin
            if (cnt_d == 3'd0) begin
                close_err = 1'b1;
            end else begin
                unique case (field_number_reg)
                    isoepoch_pkg::FLD_YEAR: begin
                        if (acc_d < isoepoch_pkg::YEAR_MIN || acc_d > isoepoch_pkg::YEAR_MAX)
                            close_err = 1'b1;
                        else
                            year_upd = 8'(acc_d - isoepoch_pkg::YEAR_MIN);
                    end
                    isoepoch_pkg::FLD_MONTH: begin
                        if (acc_d == 14'd0 || acc_d > isoepoch_pkg::MONTH_MAX)
                            close_err = 1'b1;
                        else
                            month_upd = 4'(acc_d - 14'd1);
                    end
                    isoepoch_pkg::FLD_DAY: begin
                        if (acc_d == 14'd0 || acc_d > isoepoch_pkg::DAY_MAX)
                            close_err = 1'b1;
                        else
                            day_upd = 5'(acc_d);
                    end
                    isoepoch_pkg::FLD_HOUR: begin
                        if (acc_d > isoepoch_pkg::HOUR_MAX)
                            close_err = 1'b1;
                        else
                            hour_upd = 5'(acc_d);
                    end
                    isoepoch_pkg::FLD_MINUTE: begin
                        if (acc_d > isoepoch_pkg::MINSEC_MAX)
                            close_err = 1'b1;
                        else
                            minute_upd = 6'(acc_d);
                    end
                    isoepoch_pkg::FLD_SECOND: begin
                        if (acc_d > isoepoch_pkg::MINSEC_MAX)
                            close_err = 1'b1;
                        else
                            second_upd = 6'(acc_d);
                    end
                    default: close_err = 1'b1;
                endcase
            end
        end

        err_upd = error_seen_reg || stray || overflow || close_err || end_err;
    end

    // Next parse state: cleared after every last character
    always_comb begin
        field_number_next      = field_number_reg;
        field_accumulator_next = field_accumulator_reg;
        digit_count_next       = digit_count_reg;
        year_offset_next       = year_offset_reg;
        month_index_next       = month_index_reg;
        day_of_month_next      = day_of_month_reg;
        hour_value_next        = hour_value_reg;
        minute_value_next      = minute_value_reg;
        error_seen_next        = error_seen_reg;
        if (in_acc) begin
            if (s_is_last) begin
                field_number_next      = isoepoch_pkg::FLD_YEAR;
                field_accumulator_next = '0;
                digit_count_next       = '0;
                year_offset_next       = '0;
                month_index_next       = '0;
                day_of_month_next      = '0;
                hour_value_next        = '0;
                minute_value_next      = '0;
                error_seen_next        = 1'b0;
            end else begin
                field_number_next      = sep_hit ?
                    isoepoch_pkg::field_t'(3'(field_number_reg + 3'd1)) : field_number_reg;
                field_accumulator_next = sep_hit ? 14'd0 : acc_d;
                digit_count_next       = sep_hit ? 3'd0 : cnt_d;
                year_offset_next       = year_upd;
                month_index_next       = month_upd;
                day_of_month_next      = day_upd;
                hour_value_next        = hour_upd;
                minute_value_next      = minute_upd;
                error_seen_next        = err_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_number_reg      <= isoepoch_pkg::FLD_YEAR;
            field_accumulator_reg <= '0;
            digit_count_reg       <= '0;
            year_offset_reg       <= '0;
            month_index_reg       <= '0;
            day_of_month_reg      <= '0;
            hour_value_reg        <= '0;
            minute_value_reg      <= '0;
            error_seen_reg        <= 1'b0;
        end else begin
            field_number_reg      <= field_number_next;
            field_accumulator_reg <= field_accumulator_next;
            digit_count_reg       <= digit_count_next;
            year_offset_reg       <= year_offset_next;
            month_index_reg       <= month_index_next;
            day_of_month_reg      <= day_of_month_next;
            hour_value_reg        <= hour_value_next;
            minute_value_reg      <= minute_value_next;
            error_seen_reg        <= error_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: finished fields of one string
    // ------------------------------------------------------------------
    isoepoch_pkg::date_fields_t s1_reg, s1_next;
    logic s1_valid_next;

    always_comb begin
        s1_next.year_off  = year_upd;
        s1_next.month_idx = month_upd;
        s1_next.day       = day_upd;
        s1_next.hour      = hour_upd;
        s1_next.minute    = minute_upd;
        s1_next.second    = second_upd;
        s1_next.bad       = err_upd;
        s1_valid_next     = (in_acc && s_is_last) || (s1_valid_reg && !s1_adv);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_is_last) begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: day count since 1970 and seconds within the day
    // ------------------------------------------------------------------
    logic        leap;
    logic [8:0]  yday;
    logic signed [8:0] ym70, ym69, q4;
    logic [19:0] year_days, cent_sub, cent_add;
    logic [19:0] days_reg, days_next;
    logic [16:0] hms_reg, hms_next;
    logic        s2_bad_reg;
    logic        s2_valid_next;

    always_comb begin
        // Gregorian leap year for 1900 + year_off (1900 and 2100 are not)
        leap = (s1_reg.year_off[1:0] == 2'b00) &&
               (s1_reg.year_off != 8'd0) &&
               (s1_reg.year_off != isoepoch_pkg::YEAR_CENTURY_2);
        yday = isoepoch_pkg::days_before_month(s1_reg.month_idx) +
               9'(leap && (s1_reg.month_idx >= 4'd2)) +
               9'(s1_reg.day) - 9'd1;

        ym70 = signed'({1'b0, s1_reg.year_off}) - signed'(isoepoch_pkg::EPOCH_YEAR_OFF);
        ym69 = signed'({1'b0, s1_reg.year_off}) - signed'(isoepoch_pkg::LEAP_BASE_OFF);
        q4   = ym69 >>> 2;                      // floor((y - 69) / 4)

        // floor((y - 1) / 100) and floor((y + 299) / 400) over the byte range
        if (s1_reg.year_off == 8'd0)
            cent_sub = 20'hFFFFF;
        else if (s1_reg.year_off <= isoepoch_pkg::YEAR_CENTURY_1)
            cent_sub = 20'd0;
        else if (s1_reg.year_off <= isoepoch_pkg::YEAR_CENTURY_2)
            cent_sub = 20'd1;
        else
            cent_sub = 20'd2;
        cent_add = 20'(s1_reg.year_off > isoepoch_pkg::YEAR_CENTURY_1);

        year_days = {{11{ym70[8]}}, ym70} * isoepoch_pkg::DAYS_PER_YEAR;
        days_next = 20'(yday) + year_days + {{11{q4[8]}}, q4} - cent_sub + cent_add;
        hms_next  = 17'(s1_reg.hour) * isoepoch_pkg::SEC_PER_HOUR +
                    17'(s1_reg.minute) * isoepoch_pkg::SEC_PER_MIN +
                    17'(s1_reg.second);
        s2_valid_next = s1_adv || (s2_valid_reg && !s2_adv);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            days_reg   <= days_next;
            hms_reg    <= hms_next;
            s2_bad_reg <= s1_reg.bad;
        end
    end

    // ------------------------------------------------------------------
    // Output register: days * 86400 + seconds of day, modulo 2^32
    // ------------------------------------------------------------------
    logic [31:0] epoch_reg, epoch_next;
    logic        bad_reg;
    logic        m_valid_next;

    always_comb begin
        epoch_next   = {{12{days_reg[19]}}, days_reg} * isoepoch_pkg::SEC_PER_DAY +
                       32'(hms_reg);
        m_valid_next = s2_adv || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            epoch_reg <= s2_bad_reg ? 32'd0 : epoch_next;
            bad_reg   <= s2_bad_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_epoch_seconds = epoch_reg;
    assign m_bad_format    = bad_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ISOEP_ASSERT_NEXT(a_last_loads_s1, in_acc && s_is_last, s1_valid_reg,
        "last item did not reach the field stage")
    `ISOEP_ASSERT_NEXT(a_last_clears_state, in_acc && s_is_last,
        field_number_reg == isoepoch_pkg::FLD_YEAR && digit_count_reg == 3'd0 &&
        !error_seen_reg, "parse state not cleared after last item")
    `ISOEP_ASSERT_IMP(a_digit_limit,
        field_number_reg != isoepoch_pkg::FLD_YEAR, digit_count_reg <= 3'd2,
        "too many digits held in a short field")
    `ISOEP_ASSERT_IMP(a_bad_is_zero, m_valid && m_bad_format, m_epoch_seconds == 32'd0,
        "bad result carries nonzero seconds")

endmodule
